// File: rtl/rab_pkg.sv
// rab_pkg: shared constants, types and helpers of the RGB565 pixel write engine.
// Used by every module of the block; depends on nothing.
package rab_pkg;

  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  localparam int GEOM_W  = 8;
  localparam int POS_W   = 11;
  localparam int COLOR_W = 16;
  localparam int ALPHA_W = 8;
  localparam int CHAN_W  = 8;
  localparam int MIX_W   = 16;

  localparam logic [GEOM_W-1:0] WIDTH_LIMIT  = GEOM_W'(MAX_WIDTH);
  localparam logic [GEOM_W-1:0] HEIGHT_LIMIT = GEOM_W'(MAX_HEIGHT);
  localparam logic [ADDR_W-1:0] LAST_ADDR    = ADDR_W'(DEPTH - 1);

  localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [ALPHA_W-1:0] ALPHA_NONE   = 8'd0;

  localparam logic CMD_PUT   = 1'b0;
  localparam logic CMD_BLEND = 1'b1;

  localparam logic [0:0] REG_FB_WIDTH  = 1'b0;
  localparam logic [0:0] REG_FB_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_READ,
    ST_MUL,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic               we;
    logic               re;
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] wdata;
  } ram_req_t;

  function automatic logic [COLOR_W-1:0] byte_swap(input logic [COLOR_W-1:0] v);
    return {v[7:0], v[15:8]};
  endfunction

endpackage

// File: rtl/rab_frame_ram.sv
// rab_frame_ram: single-port framebuffer memory, one access per cycle,
// registered read data. Depends on rab_pkg for geometry and the request struct.
module rab_frame_ram (
  input  logic                        clk,
  input  rab_pkg::ram_req_t           req,
  output logic [rab_pkg::COLOR_W-1:0] rdata
);

  logic [rab_pkg::COLOR_W-1:0] mem [rab_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

// File: rtl/rab_blend.sv
// rab_blend: per-channel alpha mix of a source color over a stored word.
// Stage one registers d*255 + (s-d)*a per channel; the result divides by 255
// and repacks to a byte-swapped RGB565 word. Depends on rab_pkg.
module rab_blend (
  input  logic                        clk,
  input  logic                        load,
  input  logic [rab_pkg::COLOR_W-1:0] color,
  input  logic [rab_pkg::COLOR_W-1:0] dst_word,
  input  logic [rab_pkg::ALPHA_W-1:0] alpha,
  output logic [rab_pkg::COLOR_W-1:0] blend_word
);

  logic [rab_pkg::COLOR_W-1:0] dst;
  logic [rab_pkg::CHAN_W-1:0]  s_ch [3];
  logic [rab_pkg::CHAN_W-1:0]  d_ch [3];
  logic [rab_pkg::CHAN_W-1:0]  q_ch [3];
  logic [rab_pkg::MIX_W-1:0]   mix_next [3];
  logic [rab_pkg::MIX_W-1:0]   mix [3];

  assign dst = rab_pkg::byte_swap(dst_word);

  assign s_ch[0] = {color[15:11], 3'b000};
  assign s_ch[1] = {color[10:5], 2'b00};
  assign s_ch[2] = {color[4:0], 3'b000};
  assign d_ch[0] = {dst[15:11], 3'b000};
  assign d_ch[1] = {dst[10:5], 2'b00};
  assign d_ch[2] = {dst[4:0], 3'b000};

  for (genvar c = 0; c < 3; c++) begin : g_chan
    logic signed [8:0]  diff;
    logic signed [17:0] base;
    logic signed [17:0] prod;
    logic signed [17:0] sum;
    logic [rab_pkg::MIX_W:0] t;

    assign diff = $signed({1'b0, s_ch[c]}) - $signed({1'b0, d_ch[c]});
    assign base = $signed({2'b00, d_ch[c], 8'h00}) - $signed({10'h000, d_ch[c]});
    assign prod = diff * $signed({1'b0, alpha});
    assign sum  = base + prod;
    // sum stays within 0..65025
    assign mix_next[c] = sum[rab_pkg::MIX_W-1:0];

    always_ff @(posedge clk) begin
      if (load) begin
        mix[c] <= mix_next[c];
      end
    end

    // exact v/255 for v up to 65025
    assign t = {1'b0, mix[c]} + {9'h000, mix[c][15:8]} + 17'd1;
    assign q_ch[c] = t[15:8];
  end

  assign blend_word = rab_pkg::byte_swap({q_ch[0][7:3], q_ch[1][7:2], q_ch[2][7:3]});

endmodule

// File: rtl/rgb565_alpha_blend_pixel.sv
// rgb565_alpha_blend_pixel: pixel put/blend engine over a byte-swapped RGB565 store.
// Each word passes through accept, clip/address, memory read, multiply and finish
// steps, and no new word is taken before the last one finishes; the finish step
// waits while the output register is still held.
// Reset: a clearing pass writes zero to all 16384 words, one per cycle; no input
// is taken during it, config writes are. Registers reset to 128 x 128.
module rgb565_alpha_blend_pixel (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_index,
  input  logic [rab_pkg::GEOM_W-1:0]  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        command,
  input  logic signed [rab_pkg::POS_W-1:0] pos_x,
  input  logic signed [rab_pkg::POS_W-1:0] pos_y,
  input  logic [rab_pkg::COLOR_W-1:0] color,
  input  logic [rab_pkg::ALPHA_W-1:0] alpha,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        wrote,
  output logic                        clipped,
  output logic [rab_pkg::ADDR_W-1:0]  address,
  output logic [rab_pkg::COLOR_W-1:0] stored_word
);

  rab_pkg::state_t state, state_next;

  logic [rab_pkg::GEOM_W-1:0]  fb_width, fb_height;
  logic [rab_pkg::ADDR_W-1:0]  clr_cnt;

  logic                        cmd_r;
  logic [rab_pkg::POS_W-1:0]   x_r, y_r;
  logic [rab_pkg::COLOR_W-1:0] color_r;
  logic [rab_pkg::ALPHA_W-1:0] alpha_r;

  logic                        clip_r, do_write_r, blend_r;
  logic [rab_pkg::ADDR_W-1:0]  addr_r;

  logic [rab_pkg::GEOM_W-1:0]  w_sat, h_sat;
  logic                        clip_next, do_write_next, blend_next;
  logic [rab_pkg::ADDR_W-1:0]  addr_next;

  rab_pkg::ram_req_t           ram_req;
  logic [rab_pkg::COLOR_W-1:0] ram_rdata;
  logic [rab_pkg::COLOR_W-1:0] blend_word, final_word;
  logic                        blend_load, fin_go, accept;

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      fb_width  <= rab_pkg::WIDTH_LIMIT;
      fb_height <= rab_pkg::HEIGHT_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rab_pkg::REG_FB_WIDTH:  fb_width  <= cfg_wdata;
        rab_pkg::REG_FB_HEIGHT: fb_height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign w_sat = (fb_width  > rab_pkg::WIDTH_LIMIT)  ? rab_pkg::WIDTH_LIMIT  : fb_width;
  assign h_sat = (fb_height > rab_pkg::HEIGHT_LIMIT) ? rab_pkg::HEIGHT_LIMIT : fb_height;

  // clip and address of the held word
  always_comb begin
    clip_next = x_r[rab_pkg::POS_W-1] || y_r[rab_pkg::POS_W-1] ||
                (x_r >= rab_pkg::POS_W'(w_sat)) || (y_r >= rab_pkg::POS_W'(h_sat));
    do_write_next = !clip_next && ((cmd_r == rab_pkg::CMD_PUT) ||
                                   (alpha_r != rab_pkg::ALPHA_NONE));
    blend_next = (cmd_r == rab_pkg::CMD_BLEND) && (alpha_r != rab_pkg::ALPHA_NONE) &&
                 (alpha_r != rab_pkg::ALPHA_OPAQUE);
    addr_next = rab_pkg::ADDR_W'(y_r[rab_pkg::ROW_W-1:0]) * rab_pkg::ADDR_W'(w_sat) +
                rab_pkg::ADDR_W'(x_r[rab_pkg::COL_W-1:0]);
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= command;
      x_r     <= pos_x;
      y_r     <= pos_y;
      color_r <= color;
      alpha_r <= alpha;
    end
    if (state == rab_pkg::ST_ADDR) begin
      clip_r     <= clip_next;
      do_write_r <= do_write_next;
      blend_r    <= blend_next;
      addr_r     <= addr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= rab_pkg::ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == rab_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rab_pkg::ST_CLEAR: if (clr_cnt == rab_pkg::LAST_ADDR) state_next = rab_pkg::ST_IDLE;
      rab_pkg::ST_IDLE:  if (in_valid) state_next = rab_pkg::ST_ADDR;
      rab_pkg::ST_ADDR:  state_next = rab_pkg::ST_READ;
      rab_pkg::ST_READ:  state_next = rab_pkg::ST_MUL;
      rab_pkg::ST_MUL:   state_next = rab_pkg::ST_FIN;
      rab_pkg::ST_FIN:   if (fin_go) state_next = rab_pkg::ST_IDLE;
      default:           state_next = rab_pkg::ST_IDLE;
    endcase
  end

  assign final_word = blend_r ? blend_word : rab_pkg::byte_swap(color_r);

  always_comb begin
    in_ready   = 1'b0;
    blend_load = 1'b0;
    fin_go     = 1'b0;
    ram_req    = '0;
    unique case (state)
      rab_pkg::ST_CLEAR: begin
        ram_req.we   = 1'b1;
        ram_req.addr = clr_cnt;
      end
      rab_pkg::ST_IDLE: in_ready = 1'b1;
      rab_pkg::ST_ADDR: ;
      rab_pkg::ST_READ: begin
        ram_req.re   = 1'b1;
        ram_req.addr = addr_r;
      end
      rab_pkg::ST_MUL: blend_load = 1'b1;
      rab_pkg::ST_FIN: begin
        fin_go        = !out_valid || out_ready;
        ram_req.we    = fin_go && do_write_r;
        ram_req.addr  = addr_r;
        ram_req.wdata = final_word;
      end
      default: ;
    endcase
  end

  rab_frame_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  rab_blend u_blend (
    .clk        (clk),
    .load       (blend_load),
    .color      (color_r),
    .dst_word   (ram_rdata),
    .alpha      (alpha_r),
    .blend_word (blend_word)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      wrote       <= do_write_r;
      clipped     <= clip_r;
      address     <= do_write_r ? addr_r : '0;
      stored_word <= do_write_r ? final_word : '0;
    end
  end

endmodule

// File: rtl/rab_checker.sv
// rab_checker: port-level assertions for rgb565_alpha_blend_pixel, attached by bind.
// Depends on rab_pkg for field widths.
module rab_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        wrote,
  input logic                        clipped,
  input logic [rab_pkg::ADDR_W-1:0]  address,
  input logic [rab_pkg::COLOR_W-1:0] stored_word
);

  // clearing pass follows reset, no word taken
  a_clear_after_rst: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input ready right after reset");

  // one word in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word taken while one is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(address) &&
                                   $stable(stored_word) && $stable(wrote)))
    else $error("stalled result changed");

  a_clip_no_write: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clipped) |-> !wrote)
    else $error("clipped word reported as written");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !wrote) |-> (address == '0 && stored_word == '0))
    else $error("non-write result carries address or data");

endmodule

bind rgb565_alpha_blend_pixel rab_checker u_rab_checker (.*);

// File: dv/rgb565_alpha_blend_pixel_tb.sv
// rgb565_alpha_blend_pixel_tb: self-checking bench for the RGB565 pixel put/blend engine.
// Depends on rab_pkg and rtl/rgb565_alpha_blend_pixel.sv; keeps its own frame copy to
// predict every result word and drives both handshakes with random gaps.
module rgb565_alpha_blend_pixel_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    logic                        wrote;
    logic                        clipped;
    logic [rab_pkg::ADDR_W-1:0]  address;
    logic [rab_pkg::COLOR_W-1:0] stored_word;
  } pixel_write_t;

  class pixel_scoreboard;
    logic [rab_pkg::COLOR_W-1:0] frame [rab_pkg::DEPTH];
    logic [rab_pkg::GEOM_W-1:0]  width_reg;
    logic [rab_pkg::GEOM_W-1:0]  height_reg;
    pixel_write_t                due_q [$];
    int                          mismatches;

    function new();
      foreach (frame[i]) frame[i] = '0;
      width_reg  = rab_pkg::WIDTH_LIMIT;
      height_reg = rab_pkg::HEIGHT_LIMIT;
      mismatches = 0;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function logic [rab_pkg::CHAN_W-1:0] mix(int s, int d, int a);
      return rab_pkg::CHAN_W'((s * a + d * (int'(rab_pkg::ALPHA_OPAQUE) - a)) /
                              int'(rab_pkg::ALPHA_OPAQUE));
    endfunction

    function void note_input(logic cmd, logic signed [rab_pkg::POS_W-1:0] px,
                             logic signed [rab_pkg::POS_W-1:0] py,
                             logic [rab_pkg::COLOR_W-1:0] src,
                             logic [rab_pkg::ALPHA_W-1:0] a);
      pixel_write_t                res;
      int                          w, h, addr;
      logic [rab_pkg::COLOR_W-1:0] dst, packed565, word;
      logic [rab_pkg::CHAN_W-1:0]  r, g, b;
      res = '{1'b0, 1'b0, '0, '0};
      // oversized geometry saturates to the store size
      w = (width_reg > rab_pkg::WIDTH_LIMIT) ? int'(rab_pkg::WIDTH_LIMIT) : int'(width_reg);
      h = (height_reg > rab_pkg::HEIGHT_LIMIT) ? int'(rab_pkg::HEIGHT_LIMIT)
                                                : int'(height_reg);
      if (px < 0 || py < 0 || px >= w || py >= h) begin
        res.clipped = 1'b1;
      end else if (cmd == rab_pkg::CMD_BLEND && a == rab_pkg::ALPHA_NONE) begin
        // transparent blend: no write, all fields zero
      end else begin
        addr = int'(py) * w + int'(px);
        if (cmd == rab_pkg::CMD_PUT || a == rab_pkg::ALPHA_OPAQUE) begin
          word = {src[7:0], src[15:8]};
        end else begin
          dst = {frame[addr][7:0], frame[addr][15:8]};
          r = mix({src[15:11], 3'b000}, {dst[15:11], 3'b000}, a);
          g = mix({src[10:5], 2'b00}, {dst[10:5], 2'b00}, a);
          b = mix({src[4:0], 3'b000}, {dst[4:0], 3'b000}, a);
          packed565 = {r[7:3], g[7:2], b[7:3]};
          word = {packed565[7:0], packed565[15:8]};
        end
        frame[addr]     = word;
        res.wrote       = 1'b1;
        res.address     = rab_pkg::ADDR_W'(addr);
        res.stored_word = word;
      end
      due_q.push_back(res);
    endfunction

    function void check_result(pixel_write_t got);
      pixel_write_t want;
      if (due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR %0t: unexpected word wrote=%0b clipped=%0b address=%0d data=%h",
                   $time, got.wrote, got.clipped, got.address, got.stored_word);
        return;
      end
      want = due_q.pop_front();
      if (got.wrote !== want.wrote || got.clipped !== want.clipped ||
          got.address !== want.address || got.stored_word !== want.stored_word) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR %0t: expected %0b %0b %0d %h, got %0b %0b %0d %h", $time,
                   want.wrote, want.clipped, want.address, want.stored_word,
                   got.wrote, got.clipped, got.address, got.stored_word);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                             cfg_we = 1'b0;
  logic [0:0]                       cfg_index = rab_pkg::REG_FB_WIDTH;
  logic [rab_pkg::GEOM_W-1:0]       cfg_wdata = '0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic                             command = rab_pkg::CMD_PUT;
  logic signed [rab_pkg::POS_W-1:0] pos_x = '0;
  logic signed [rab_pkg::POS_W-1:0] pos_y = '0;
  logic [rab_pkg::COLOR_W-1:0]      color = '0;
  logic [rab_pkg::ALPHA_W-1:0]      alpha = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic                             wrote;
  logic                             clipped;
  logic [rab_pkg::ADDR_W-1:0]       address;
  logic [rab_pkg::COLOR_W-1:0]      stored_word;

  pixel_scoreboard sb = new();
  logic            steady = 1'b0;
  int unsigned     cycle_count = 0;

  rgb565_alpha_blend_pixel i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .color       (color),
    .alpha       (alpha),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .wrote       (wrote),
    .clipped     (clipped),
    .address     (address),
    .stored_word (stored_word)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // everything is stable at the falling edge, so handshakes seen here
  // are exactly the ones taken at the next rising edge
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.note_input(command, pos_x, pos_y, color, alpha);
      if (out_valid && out_ready)
        sb.check_result('{wrote, clipped, address, stored_word});
    end
  end

  function automatic int pick_gap();
    int roll;
    if (steady)
      return 0;
    roll = $urandom_range(0, 99);
    if (roll < 45)
      return 0;
    if (roll < 85)
      return $urandom_range(1, 3);
    if (roll < 97)
      return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  initial begin : sink_pacing
    int n;
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      n = pick_gap();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  // called at a rising edge; returns at the edge where the word is taken
  task automatic send_word(logic cmd, logic signed [rab_pkg::POS_W-1:0] px,
                           logic signed [rab_pkg::POS_W-1:0] py,
                           logic [rab_pkg::COLOR_W-1:0] src,
                           logic [rab_pkg::ALPHA_W-1:0] a);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    pos_x    <= px;
    pos_y    <= py;
    color    <= src;
    alpha    <= a;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic drain_words();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic set_geometry(logic [rab_pkg::GEOM_W-1:0] w,
                              logic [rab_pkg::GEOM_W-1:0] h);
    drain_words();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= rab_pkg::REG_FB_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= rab_pkg::REG_FB_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.width_reg  = w;
    sb.height_reg = h;
  endtask

  task automatic send_random(int w, int h);
    logic                             cmd;
    logic signed [rab_pkg::POS_W-1:0] px, py;
    logic [rab_pkg::COLOR_W-1:0]      src;
    logic [rab_pkg::ALPHA_W-1:0]      a;
    int                               roll;
    roll = $urandom_range(0, 99);
    if (roll < 70 && w > 0 && h > 0) begin
      if (roll < 35) begin
        // tight corner so blends stack on pixels already written
        px = rab_pkg::POS_W'($urandom_range(0, (w < 4 ? w : 4) - 1));
        py = rab_pkg::POS_W'($urandom_range(0, (h < 4 ? h : 4) - 1));
      end else begin
        px = rab_pkg::POS_W'($urandom_range(0, w - 1));
        py = rab_pkg::POS_W'($urandom_range(0, h - 1));
      end
    end else if (roll < 85) begin
      px = $urandom_range(0, 1) ? rab_pkg::POS_W'(-1) : rab_pkg::POS_W'(w);
      py = rab_pkg::POS_W'($urandom_range(0, h > 0 ? h - 1 : 0));
      if ($urandom_range(0, 1))
        {px, py} = {py, px};
    end else begin
      px = rab_pkg::POS_W'($urandom);
      py = rab_pkg::POS_W'($urandom);
    end
    cmd  = ($urandom_range(0, 99) < 60) ? rab_pkg::CMD_BLEND : rab_pkg::CMD_PUT;
    roll = $urandom_range(0, 9);
    src  = (roll == 0) ? '1 : (roll == 1) ? '0 : rab_pkg::COLOR_W'($urandom);
    roll = $urandom_range(0, 99);
    a    = (roll < 15) ? rab_pkg::ALPHA_NONE :
           (roll < 30) ? rab_pkg::ALPHA_OPAQUE : rab_pkg::ALPHA_W'($urandom);
    send_word(cmd, px, py, src, a);
  endtask

  logic [rab_pkg::GEOM_W-1:0] plan_w [8] = '{128, 1, 0, 128, 1, 200, 7, 255};
  logic [rab_pkg::GEOM_W-1:0] plan_h [8] = '{128, 1, 50, 1, 128, 255, 5, 0};

  initial begin
    logic [rab_pkg::GEOM_W-1:0] gw, gh;
    int                         ew, eh, count, hold_at;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed words at the reset geometry of 128 x 128
    send_word(rab_pkg::CMD_PUT,   0,     0,     16'hFFFF, 8'h00);
    send_word(rab_pkg::CMD_PUT,   127,   127,   16'h0000, 8'hFF);
    send_word(rab_pkg::CMD_PUT,   127,   0,     16'hA5C3, 8'h5A);
    send_word(rab_pkg::CMD_PUT,   0,     127,   16'h5A3C, 8'hA5);
    send_word(rab_pkg::CMD_BLEND, 0,     0,     16'h0000, 8'h80);
    send_word(rab_pkg::CMD_BLEND, 0,     0,     16'hF800, 8'h01);
    send_word(rab_pkg::CMD_BLEND, 0,     0,     16'h07E0, 8'hFE);
    send_word(rab_pkg::CMD_BLEND, 0,     0,     16'h001F, rab_pkg::ALPHA_NONE);
    send_word(rab_pkg::CMD_BLEND, 0,     0,     16'h1234, rab_pkg::ALPHA_OPAQUE);
    send_word(rab_pkg::CMD_BLEND, 127,   0,     16'hFFFF, 8'h80);
    send_word(rab_pkg::CMD_BLEND, 5,     5,     16'hFFFF, 8'h40);
    send_word(rab_pkg::CMD_PUT,   -1,    0,     16'hFFFF, 8'h00);
    send_word(rab_pkg::CMD_PUT,   128,   0,     16'hFFFF, 8'h00);
    send_word(rab_pkg::CMD_PUT,   0,     128,   16'hFFFF, 8'h00);
    send_word(rab_pkg::CMD_BLEND, -1024, -1024, 16'hFFFF, 8'h80);
    send_word(rab_pkg::CMD_PUT,   1023,  1023,  16'hFFFF, 8'hFF);
    send_word(rab_pkg::CMD_PUT,   5,     -1,    16'h8421, 8'h00);
    send_word(rab_pkg::CMD_BLEND, 128,   127,   16'h7BEF, rab_pkg::ALPHA_NONE);
    send_word(rab_pkg::CMD_PUT,   64,    64,    16'hF81F, 8'h00);
    send_word(rab_pkg::CMD_BLEND, 64,    64,    16'h0000, 8'hC0);

    for (int phase = 0; phase < 13; phase++) begin
      if (phase < 8) begin
        gw = plan_w[phase];
        gh = plan_h[phase];
      end else begin
        gw = ($urandom_range(0, 4) == 0) ? rab_pkg::GEOM_W'($urandom_range(129, 255))
                                         : rab_pkg::GEOM_W'($urandom_range(1, 128));
        gh = ($urandom_range(0, 4) == 0) ? rab_pkg::GEOM_W'($urandom_range(129, 255))
                                         : rab_pkg::GEOM_W'($urandom_range(1, 128));
      end
      steady = (phase % 4 == 1);
      set_geometry(gw, gh);
      ew = (gw > rab_pkg::WIDTH_LIMIT) ? int'(rab_pkg::WIDTH_LIMIT) : int'(gw);
      eh = (gh > rab_pkg::HEIGHT_LIMIT) ? int'(rab_pkg::HEIGHT_LIMIT) : int'(gh);
      count = (ew == 0 || eh == 0) ? 30 : 110;
      hold_at = (phase % 3 == 0) ? $urandom_range(10, count - 10) : -1;
      for (int k = 0; k < count; k++) begin
        if (k == hold_at)
          drain_words();
        send_random(ew, eh);
      end
    end

    drain_words();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
